### sv/cartridge_bank_controller_unit_assert.svh
// Assertion macros for the cartridge bank controller.
// Included by the top level; no other dependencies.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CBC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("cartridge bank controller check failed");

// Next-cycle implication.
`define CBC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("cartridge bank controller check failed");

`endif

### sv/cbc_pkg.sv
// Shared types and constants of the cartridge bank controller.
// No dependencies.
package cbc_pkg;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;

   localparam logic [1:0] CTRL_NONE = 2'd0;
   localparam logic [1:0] CTRL_MBC1 = 2'd1;
   localparam logic [1:0] CTRL_MBC2 = 2'd2;
   localparam logic [1:0] CTRL_MBC3 = 2'd3;

   // bus_address[15:13] regions
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_ROM_PAGE   = 3'd1;
   localparam logic [2:0] REGION_RAM_PAGE   = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;
   localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

   localparam logic [3:0] ENABLE_KEY = 4'hA;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_ROM,
      SRC_RAM
   } src_type;

   typedef struct packed {
      logic       rom_rd;
      logic       ram_rd;
      logic       ram_wr;
      logic       claimed;
      src_type    src;
      logic [6:0] rom_page;
      logic [1:0] ram_page;
   } map_type;

endpackage

### sv/cartridge_bank_controller_unit.sv
// Top level of the cartridge bank controller: ROM and RAM memories, pipeline.
// Depends on cbc_pkg, cbc_bank_regs and cartridge_bank_controller_unit_assert.svh.
//
// Usage:
//  req_* carries one item per handshake: bus read, bus write or ROM load byte.
//  rsp_* returns exactly one item per request, in order: read_data and claimed.
//  csr_* writes controller_type; csr_ready is always high. Write it while idle.
//  Throughput: one item per cycle while rsp_ready is high and the RAM clear is
//  done. Bank register writes take effect for the very next item. Read data
//  is registered in the memory read stage when the item is accepted and moves
//  to the output register, which drives rsp_valid, when that register is free.
//  Reset: bank registers return to their defaults and the external RAM is
//  cleared by a pass over every address, one byte per cycle, during which
//  req_ready stays low. ROM contents are undefined until loaded.
//  Stall: when rsp_ready is low the result is held; one more item can sit in
//  the memory read stage, after which req_ready drops until the output drains.
module cartridge_bank_controller_unit #(
   parameter int ROM_BYTES = 2097152,
   parameter int RAM_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [20:0] req_load_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_claimed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_controller_type
);

   localparam int ROM_AW = $clog2(ROM_BYTES);
   localparam int RAM_AW = $clog2(RAM_BYTES);

   logic [1:0]        ctrl_type_ff;
   logic              clearing_ff;
   logic [RAM_AW-1:0] clr_cnt_ff;
   logic              accept;
   cbc_pkg::map_type  map;

   logic [31:0]       rom_lin;
   logic [31:0]       ram_lin;
   logic [ROM_AW-1:0] rom_addr;
   logic [RAM_AW-1:0] ram_addr;
   logic [RAM_AW-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              rom_we, rom_re, ram_we, ram_re;

   logic [7:0]        rom_mem [ROM_BYTES];
   logic [7:0]        ram_mem [RAM_BYTES];
   logic [7:0]        rom_q_ff;
   logic [7:0]        ram_q_ff;

   logic              s1_valid_ff, s1_valid_in;
   cbc_pkg::src_type  s1_src_ff;
   logic              s1_claimed_ff;
   logic              s1_adv;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_claimed_ff;
   logic [7:0]        s1_data;

   assign csr_ready = 1'b1;
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset)
         ctrl_type_ff <= cbc_pkg::CTRL_NONE;
      else if (csr_valid)
         ctrl_type_ff <= csr_controller_type;
   end

   cbc_bank_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ctrl_type   (ctrl_type_ff),
      .mode        (req_mode),
      .bus_address (req_bus_address),
      .write_data  (req_write_data),
      .map         (map)
   );

   always_comb begin
      if (req_mode == cbc_pkg::MODE_LOAD)
         rom_lin = {11'd0, req_load_address};
      else if (req_bus_address[14])
         rom_lin = {11'd0, map.rom_page, req_bus_address[13:0]};
      else
         rom_lin = {18'd0, req_bus_address[13:0]};
      ram_lin = {17'd0, map.ram_page, req_bus_address[12:0]};
   end

   assign rom_addr = rom_lin[ROM_AW-1:0];
   assign ram_addr = ram_lin[RAM_AW-1:0];
   assign rom_we   = accept && (req_mode == cbc_pkg::MODE_LOAD);
   assign rom_re   = accept && map.rom_rd;
   assign ram_re   = accept && map.ram_rd;
   assign ram_we   = clearing_ff || (accept && map.ram_wr);
   assign ram_waddr = clearing_ff ? clr_cnt_ff : ram_addr;
   assign ram_wdata = clearing_ff ? 8'd0 : req_write_data;

   always_ff @(posedge clock) begin
      if (rom_we)
         rom_mem[rom_addr] <= req_write_data;
      if (rom_re)
         rom_q_ff <= rom_mem[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (ram_we)
         ram_mem[ram_waddr] <= ram_wdata;
      if (ram_re)
         ram_q_ff <= ram_mem[ram_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + RAM_AW'(1);
         if (&clr_cnt_ff)
            clearing_ff <= 1'b0;
      end
   end

   always_comb begin
      case (s1_src_ff)
         cbc_pkg::SRC_ROM: s1_data = rom_q_ff;
         cbc_pkg::SRC_RAM: s1_data = ram_q_ff;
         default:          s1_data = 8'd0;
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)
         s1_valid_in = 1'b1;
      else if (s1_adv)
         s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)
         rsp_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff     <= map.src;
         s1_claimed_ff <= map.claimed;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff    <= s1_data;
         rsp_claimed_ff <= s1_claimed_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_claimed   = rsp_claimed_ff;

`include "cartridge_bank_controller_unit_assert.svh"

   `CBC_ASSERT_NOW(a_no_accept_clearing, clock, reset, clearing_ff, !req_ready)
   `CBC_ASSERT_NOW(a_unclaimed_zero, clock, reset, rsp_valid && !rsp_claimed, rsp_data_ff == '0)
   `CBC_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)
   `CBC_ASSERT_NOW(a_bank_nonzero, clock, reset, 1'b1, map.rom_page != 7'd0)

endmodule

### sv/cbc_bank_regs.sv
// Bank registers and bus decode of the cartridge bank controller.
// Depends on cbc_pkg.
module cbc_bank_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         ctrl_type,
   input  logic [1:0]         mode,
   input  logic [15:0]        bus_address,
   input  logic [7:0]         write_data,
   output cbc_pkg::map_type   map
);

   logic [6:0] rom_page_ff, rom_page_in;
   logic [1:0] ram_page_ff, ram_page_in;
   logic       bank_mode_ff, bank_mode_in;
   logic       ram_en_ff, ram_en_in;
   logic       clk_sel_ff, clk_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_page_ff  <= 7'd1;
         ram_page_ff  <= 2'd0;
         bank_mode_ff <= 1'b1;
         ram_en_ff    <= 1'b0;
         clk_sel_ff   <= 1'b0;
      end else begin
         rom_page_ff  <= rom_page_in;
         ram_page_ff  <= ram_page_in;
         bank_mode_ff <= bank_mode_in;
         ram_en_ff    <= ram_en_in;
         clk_sel_ff   <= clk_sel_in;
      end
   end

   always_comb begin
      logic [2:0] region;
      logic [6:0] bank_new;
      logic       bank_wr;
      logic       key;
      logic       is_wr;
      logic       is_rd;

      region   = bus_address[15:13];
      bank_new = rom_page_ff;
      bank_wr  = 1'b0;
      key      = (write_data[3:0] == cbc_pkg::ENABLE_KEY);
      is_wr    = (mode == cbc_pkg::MODE_WRITE);
      is_rd    = (mode == cbc_pkg::MODE_READ);

      rom_page_in  = rom_page_ff;
      ram_page_in  = ram_page_ff;
      bank_mode_in = bank_mode_ff;
      ram_en_in    = ram_en_ff;
      clk_sel_in   = clk_sel_ff;

      map          = '0;
      map.src      = cbc_pkg::SRC_ZERO;
      map.rom_page = rom_page_ff;
      map.ram_page = ram_page_ff;

      if (is_wr) begin
         map.claimed = !bus_address[15] || (region == cbc_pkg::REGION_EXT_RAM);
         map.ram_wr  = (region == cbc_pkg::REGION_EXT_RAM) && !clk_sel_ff && ram_en_ff;
      end

      if (is_rd) begin
         if (!bus_address[15]) begin
            map.rom_rd  = 1'b1;
            map.claimed = 1'b1;
            map.src     = cbc_pkg::SRC_ROM;
         end else if (region == cbc_pkg::REGION_EXT_RAM) begin
            if (ctrl_type == cbc_pkg::CTRL_MBC3 && clk_sel_ff) begin
               map.claimed = 1'b1;
            end else if (ram_en_ff) begin
               map.ram_rd  = 1'b1;
               map.claimed = 1'b1;
               map.src     = cbc_pkg::SRC_RAM;
            end
         end
      end

      if (accept && is_wr) begin
         case (region)
            cbc_pkg::REGION_RAM_ENABLE: begin
               if (ctrl_type != cbc_pkg::CTRL_NONE &&
                   !(ctrl_type == cbc_pkg::CTRL_MBC2 && bus_address[8])) begin
                  ram_en_in = key;
                  if (ctrl_type == cbc_pkg::CTRL_MBC3)
                     clk_sel_in = key;
               end
            end
            cbc_pkg::REGION_ROM_PAGE: begin
               bank_wr = 1'b1;
               case (ctrl_type)
                  cbc_pkg::CTRL_MBC1: bank_new = {rom_page_ff[6:5], write_data[4:0]};
                  cbc_pkg::CTRL_MBC2: bank_new = {3'd0, write_data[3:0]};
                  cbc_pkg::CTRL_MBC3: bank_new = write_data[6:0];
                  default:            bank_wr  = 1'b0;
               endcase
            end
            cbc_pkg::REGION_RAM_PAGE: begin
               if (ctrl_type == cbc_pkg::CTRL_MBC1) begin
                  if (bank_mode_ff) begin
                     bank_wr  = 1'b1;
                     bank_new = {write_data[1:0], rom_page_ff[4:0]};
                  end else begin
                     ram_page_in = write_data[1:0];
                  end
               end else if (ctrl_type == cbc_pkg::CTRL_MBC3) begin
                  if (write_data[7:2] == 6'd0) begin
                     ram_page_in = write_data[1:0];
                     clk_sel_in  = 1'b0;
                  end else if (write_data inside {[8'd8:8'd12]}) begin
                     clk_sel_in = 1'b1;
                  end
               end
            end
            cbc_pkg::REGION_MODE: begin
               if (ctrl_type == cbc_pkg::CTRL_MBC1) begin
                  bank_mode_in = !write_data[0];
                  if (!write_data[0])
                     ram_page_in = 2'd0;
               end
            end
            default: begin
            end
         endcase
      end

      if (bank_wr)
         rom_page_in = (bank_new == 7'd0) ? 7'd1 : bank_new;
   end

endmodule

### tb/cartridge_bank_controller_unit_test.sv
// Self-checking testbench for cartridge_bank_controller_unit: directed and random
// bus reads, writes and ROM loads under all four controller types.
// Depends on cbc_pkg and the cartridge_bank_controller_unit RTL.
module cartridge_bank_controller_unit_test;

   localparam int ROM_BYTES = 2097152;
   localparam int RAM_BYTES = 32768;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 100000;
   localparam int PHASE_ITEMS = 118;

   typedef struct packed {
      logic [7:0] data;
      logic       claimed;
   } reply_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [15:0] req_bus_address;
   logic [7:0]  req_write_data;
   logic [20:0] req_load_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_data;
   logic        rsp_claimed;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_controller_type;

   // predicted cartridge state
   logic [7:0] rom_image [int unsigned];
   logic [7:0] ram_image [0:RAM_BYTES-1];
   logic [1:0] ctrl_type;
   logic [6:0] rom_page;
   logic [1:0] ram_page;
   logic       rom_mode;
   logic       ram_on;
   logic       clock_sel;

   reply_type replies_due [$];
   bit     req_up;
   bit     no_idle;
   int     failures;
   int     sent_items;
   int     n_reads, n_writes, n_loads, n_other;
   int     n_checked, n_claimed;

   cartridge_bank_controller_unit #(
      .ROM_BYTES(ROM_BYTES),
      .RAM_BYTES(RAM_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_bus_address(req_bus_address),
      .req_write_data(req_write_data),
      .req_load_address(req_load_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_claimed(rsp_claimed),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_controller_type(csr_controller_type)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [20:0] rom_position(input logic [15:0] addr);
      if (!addr[14]) begin
         return {7'd0, addr[13:0]};
      end
      return {rom_page, addr[13:0]};
   endfunction

   function automatic logic [14:0] ram_position(input logic [15:0] addr);
      return {ram_page, addr[12:0]};
   endfunction

   function automatic void apply_access(input logic [1:0] mode, input logic [15:0] addr,
                                        input logic [7:0] data, input logic [20:0] laddr,
                                        output reply_type res);
      res = '0;
      case (mode)
         cbc_pkg::MODE_READ: begin
            if (!addr[15]) begin
               res.data = rom_image[rom_position(addr)];
               res.claimed = 1'b1;
            end else if (addr[15:13] == cbc_pkg::REGION_EXT_RAM) begin
               if (ctrl_type == cbc_pkg::CTRL_MBC3 && clock_sel) begin
                  res.claimed = 1'b1;
               end else if (ram_on) begin
                  res.data = ram_image[ram_position(addr)];
                  res.claimed = 1'b1;
               end
            end
         end
         cbc_pkg::MODE_WRITE: begin
            res.claimed = !addr[15] || addr[15:13] == cbc_pkg::REGION_EXT_RAM;
            case (addr[15:13])
               cbc_pkg::REGION_RAM_ENABLE: begin
                  if (ctrl_type != cbc_pkg::CTRL_NONE &&
                      !(ctrl_type == cbc_pkg::CTRL_MBC2 && addr[8])) begin
                     if (ctrl_type == cbc_pkg::CTRL_MBC3)
                        clock_sel = data[3:0] == cbc_pkg::ENABLE_KEY;
                     ram_on = data[3:0] == cbc_pkg::ENABLE_KEY;
                  end
               end
               cbc_pkg::REGION_ROM_PAGE: begin
                  if (ctrl_type != cbc_pkg::CTRL_NONE) begin
                     case (ctrl_type)
                        cbc_pkg::CTRL_MBC1: rom_page = {rom_page[6:5], data[4:0]};
                        cbc_pkg::CTRL_MBC2: rom_page = {3'd0, data[3:0]};
                        default:            rom_page = data[6:0];
                     endcase
                     if (rom_page == 7'd0) rom_page = 7'd1;
                  end
               end
               cbc_pkg::REGION_RAM_PAGE: begin
                  if (ctrl_type == cbc_pkg::CTRL_MBC1) begin
                     if (rom_mode) begin
                        rom_page = {data[1:0], rom_page[4:0]};
                        if (rom_page == 7'd0) rom_page = 7'd1;
                     end else begin
                        ram_page = data[1:0];
                     end
                  end else if (ctrl_type == cbc_pkg::CTRL_MBC3) begin
                     if (data <= 8'd3) begin
                        ram_page = data[1:0];
                        clock_sel = 1'b0;
                     end else if (data >= 8'd8 && data <= 8'd12) begin
                        clock_sel = 1'b1;
                     end
                  end
               end
               cbc_pkg::REGION_MODE: begin
                  if (ctrl_type == cbc_pkg::CTRL_MBC1) begin
                     rom_mode = !data[0];
                     if (rom_mode) ram_page = 2'd0;
                  end
               end
               cbc_pkg::REGION_EXT_RAM: begin
                  if (!clock_sel && ram_on) ram_image[ram_position(addr)] = data;
               end
               default: ;
            endcase
         end
         cbc_pkg::MODE_LOAD: rom_image[laddr] = data;
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [7:0] data, input logic [20:0] laddr);
      int gap;
      bit ok;
      reply_type res;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         if (req_up) req_valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_up = 1'b1;
      req_mode <= mode;
      req_bus_address <= addr;
      req_write_data <= data;
      req_load_address <= laddr;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      apply_access(mode, addr, data, laddr, res);
      replies_due.push_back(res);
      sent_items++;
      case (mode)
         cbc_pkg::MODE_READ:  n_reads++;
         cbc_pkg::MODE_WRITE: n_writes++;
         cbc_pkg::MODE_LOAD:  n_loads++;
         default:             n_other++;
      endcase
   endtask

   // ROM bytes are loaded before they are read
   task automatic issue(input logic [1:0] mode, input logic [15:0] addr,
                        input logic [7:0] data, input logic [20:0] laddr);
      if (mode == cbc_pkg::MODE_READ && !addr[15] &&
          !rom_image.exists(rom_position(addr))) begin
         send_item(cbc_pkg::MODE_LOAD, 16'($urandom), 8'($urandom), rom_position(addr));
      end
      send_item(mode, addr, data, laddr);
   endtask

   task automatic drain();
      if (req_up) req_valid <= 1'b0;
      req_up = 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_controller(input logic [1:0] t);
      bit ok;
      drain();
      csr_valid <= 1'b1;
      csr_controller_type <= t;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      ctrl_type = t;
      csr_valid <= 1'b0;
   endtask

   task automatic test_plain_cartridge();
      set_controller(cbc_pkg::CTRL_NONE);
      issue(cbc_pkg::MODE_LOAD, 16'hFFFF, 8'hFF, 21'h1FFFFF);
      issue(cbc_pkg::MODE_READ, 16'h0000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'h7FFF, 8'hFF, 21'h1FFFFF);
      issue(cbc_pkg::MODE_WRITE, 16'h2000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h0000, 8'h0A, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'hA000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'hFFFF, 8'h00, 21'h000000);
      issue(MODE_UNUSED, 16'h4000, 8'h55, 21'h0AAAAA);
   endtask

   task automatic test_mbc1_banking();
      set_controller(cbc_pkg::CTRL_MBC1);
      issue(cbc_pkg::MODE_WRITE, 16'h3FFF, 8'hE0, 21'h000000);   // bank zero becomes one
      issue(cbc_pkg::MODE_WRITE, 16'h5FFF, 8'h03, 21'h000000);   // upper bank bits
      issue(cbc_pkg::MODE_READ, 16'h4000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h6000, 8'h01, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h1FFF, 8'h0A, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h4000, 8'h02, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'hBFFF, 8'h5A, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'hBFFF, 8'h00, 21'h000000);
   endtask

   task automatic test_mbc2_guard();
      set_controller(cbc_pkg::CTRL_MBC2);
      issue(cbc_pkg::MODE_WRITE, 16'h0000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h0100, 8'h0A, 21'h000000);   // address bit 8 set: ignored
      issue(cbc_pkg::MODE_READ, 16'hA000, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h2100, 8'hFF, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'h7FFF, 8'h00, 21'h000000);
   endtask

   task automatic test_mbc3_clock_select();
      set_controller(cbc_pkg::CTRL_MBC3);
      issue(cbc_pkg::MODE_WRITE, 16'h0000, 8'h0A, 21'h000000);   // enables RAM and clock
      issue(cbc_pkg::MODE_READ, 16'hA123, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'hA123, 8'h77, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h4000, 8'h05, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h4000, 8'h01, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'hA123, 8'h77, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'hA123, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h4000, 8'h0C, 21'h000000);
      issue(cbc_pkg::MODE_READ, 16'hA123, 8'h00, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h2000, 8'h80, 21'h000000);
      issue(cbc_pkg::MODE_WRITE, 16'h6000, 8'h01, 21'h000000);
   endtask

   task automatic random_step();
      int pick;
      logic [15:0] a;
      pick = $urandom_range(0, 99);
      a = 16'hA000 | 16'($urandom_range(0, 16'h1FFF));
      if (pick < 25) begin
         issue(cbc_pkg::MODE_WRITE, 16'h2000 | 16'($urandom_range(0, 16'h1FFF)),
               8'($urandom), 21'($urandom));
         issue(cbc_pkg::MODE_READ, 16'h4000 | 16'($urandom_range(0, 16'h3FFF)),
               8'($urandom), 21'($urandom));
      end else if (pick < 45) begin
         issue(cbc_pkg::MODE_WRITE, 16'($urandom_range(0, 16'h1FFF)),
               {4'($urandom), cbc_pkg::ENABLE_KEY}, 21'($urandom));
         issue(cbc_pkg::MODE_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)),
               8'($urandom_range(0, 3)), 21'($urandom));
         issue(cbc_pkg::MODE_WRITE, a, 8'($urandom), 21'($urandom));
         issue(cbc_pkg::MODE_READ, a, 8'($urandom), 21'($urandom));
      end else if (pick < 60) begin
         issue(cbc_pkg::MODE_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)),
               pick < 52 ? 8'($urandom_range(0, 15)) : 8'($urandom), 21'($urandom));
         issue(cbc_pkg::MODE_WRITE, 16'h6000 | 16'($urandom_range(0, 16'h1FFF)),
               8'($urandom), 21'($urandom));
      end else if (pick < 75) begin
         issue(cbc_pkg::MODE_READ, 16'($urandom_range(0, 16'h3FFF)), 8'($urandom),
               21'($urandom));
         issue(cbc_pkg::MODE_READ, a, 8'($urandom), 21'($urandom));
      end else if (pick < 85) begin
         issue(cbc_pkg::MODE_LOAD, 16'($urandom), 8'($urandom), 21'($urandom));
      end else begin
         issue(2'($urandom), 16'($urandom), 8'($urandom), 21'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      logic [1:0] phases [6];
      int target;
      phases = '{cbc_pkg::CTRL_MBC1, cbc_pkg::CTRL_MBC3, cbc_pkg::CTRL_NONE,
                 cbc_pkg::CTRL_MBC2, cbc_pkg::CTRL_MBC3, cbc_pkg::CTRL_MBC1};
      foreach (phases[i]) begin
         set_controller(phases[i]);
         no_idle = (i == 2);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) random_step();
      end
      no_idle = 1'b0;
   endtask

   initial begin : response_side
      int stall;
      bit got;
      bit rsp_up;
      logic [7:0] data;
      logic claimed;
      reply_type want;
      rsp_up = 1'b0;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            if (rsp_up) rsp_ready <= 1'b0;
            rsp_up = 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         rsp_up = 1'b1;
         do begin
            @(negedge clock);
            got = rsp_valid;
            data = rsp_read_data;
            claimed = rsp_claimed;
            @(posedge clock);
         end while (!got);
         n_checked++;
         if (claimed === 1'b1) n_claimed++;
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected result item: read_data %h claimed %b",
                     $time, data, claimed);
            failures++;
         end else begin
            want = replies_due.pop_front();
            if (data !== want.data) begin
               $display("%0t: read_data expected %h actual %h", $time, want.data, data);
               failures++;
            end
            if (claimed !== want.claimed) begin
               $display("%0t: claimed expected %b actual %b", $time, want.claimed, claimed);
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $time, quiet);
      $display("cartridge_bank_controller_unit: mismatch");
      $finish;
   end

   initial begin
      for (int i = 0; i < RAM_BYTES; i++) ram_image[i] = 8'h00;
      ctrl_type = cbc_pkg::CTRL_NONE;
      rom_page = 7'd1;
      ram_page = 2'd0;
      rom_mode = 1'b1;
      ram_on = 1'b0;
      clock_sel = 1'b0;
      req_up = 1'b0;
      no_idle = 1'b0;
      failures = 0;
      sent_items = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= cbc_pkg::MODE_READ;
      req_bus_address <= '0;
      req_write_data <= '0;
      req_load_address <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_controller_type <= cbc_pkg::CTRL_NONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_cartridge();
      test_mbc1_banking();
      test_mbc2_guard();
      test_mbc3_clock_select();
      test_random_traffic();
      drain();

      $display("run covered %0d reads, %0d writes, %0d ROM loads, %0d unused-mode items",
               n_reads, n_writes, n_loads, n_other);
      $display("%0d results checked (%0d claimed) over all controller types, %0d errors",
               n_checked, n_claimed, failures);
      if (failures == 0) begin
         $display("cartridge_bank_controller_unit: match");
      end else begin
         $display("cartridge_bank_controller_unit: mismatch");
      end
      $finish;
   end

endmodule
